[src/vdm_pkg.sv]
package vdm_pkg;

	// Result field width, fixed by the output port
	localparam int OUT_WIDTH = 48;

	// metric_mode register
	localparam int MODE_WIDTH = 2;
	localparam logic [MODE_WIDTH-1:0] MODE_EUCLID  = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_SQUARED = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_DOT     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_FIN,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;    // capture operands of an accepted pair
		logic mul_en;  // register the product
		logic acc_en;  // saturating add into the running sum
		logic clr;     // vector finished, clear sum and flag
	} mac_ctrl_t;

endpackage

[src/vdm_mac.sv]
module vdm_mac #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vdm_pkg::mac_ctrl_t           ctrl,
	input  logic                         dot,
	input  logic signed [ELEM_WIDTH-1:0] first_elem,
	input  logic signed [ELEM_WIDTH-1:0] second_elem,
	input  logic                         first_present,
	input  logic                         second_present,
	output logic signed [ACC_WIDTH-1:0]  sum,
	output logic                         ovf
);

	localparam int OP_WIDTH   = ELEM_WIDTH + 1;
	localparam int PROD_WIDTH = 2 * OP_WIDTH;
	localparam int SUM_WIDTH  = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic signed [OP_WIDTH-1:0]   a_ext, b_ext, diff;
	logic signed [OP_WIDTH-1:0]   op_a_q, op_b_q;
	logic signed [PROD_WIDTH-1:0] prod_q;
	logic signed [SUM_WIDTH-1:0]  sum_ext;
	logic signed [ACC_WIDTH-1:0]  sum_q;
	logic                         ovf_q;

	// absent element reads as zero
	assign a_ext = first_present  ? OP_WIDTH'(first_elem)  : '0;
	assign b_ext = second_present ? OP_WIDTH'(second_elem) : '0;
	assign diff  = a_ext - b_ext;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_a_q <= dot ? a_ext : diff;
			op_b_q <= dot ? b_ext : diff;
		end
		if (ctrl.mul_en) begin
			prod_q <= op_a_q * op_b_q;
		end
	end

	assign sum_ext = SUM_WIDTH'(sum_q) + SUM_WIDTH'(prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.clr) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctrl.acc_en) begin
			priority if (sum_ext > SUM_WIDTH'(ACC_MAX)) begin
				sum_q <= ACC_MAX;
				ovf_q <= 1'b1;
			end else if (sum_ext < SUM_WIDTH'(ACC_MIN)) begin
				sum_q <= ACC_MIN;
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_ext[ACC_WIDTH-1:0];
			end
		end
	end

	assign sum = sum_q;
	assign ovf = ovf_q;

endmodule

[src/vdm_sqrt.sv]
module vdm_sqrt #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [ACC_WIDTH-1:0]        operand,
	output logic                               busy,
	output logic [(ACC_WIDTH+1)/2-1:0]         root
);

	// one result bit per cycle, restoring digit-by-digit method
	localparam int NB  = (ACC_WIDTH + 1) / 2;
	localparam int CW  = $clog2(NB);

	logic [2*NB-1:0] n_q;
	logic [NB:0]     rem_q;
	logic [NB-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [NB+2:0]   rem_shift, trial, rem_diff;
	logic            take;

	assign rem_shift = {rem_q, n_q[2*NB-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign take      = (rem_shift >= trial);
	assign rem_diff  = rem_shift - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NB - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// negative sum (mode changed mid-vector) roots to zero
			n_q    <= operand[ACC_WIDTH-1] ? '0 : (2*NB)'(unsigned'(operand));
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[2*NB-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_diff[NB:0];
				root_q <= {root_q[NB-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift[NB:0];
				root_q <= {root_q[NB-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

[src/vector_distance_metric_top.sv]
// Vector distance metric. Two vectors stream in as element pairs, one pair per input
// transfer; a clear present bit counts that element as zero, so the shorter vector is
// padded up to the longer length. Each pair adds one term to a saturating signed
// ACC_WIDTH accumulator: (a-b)^2 for the two distance forms, a*b for the dot product.
// On the pair flagged is_last a single result transfer follows: metric_mode 0 gives the
// floor integer square root of the sum (Euclidean distance, element scale kept), 1 the
// squared distance, 2 (and 3) the dot product; saturated reports any clamping in that
// vector, after which sum and flag are cleared. The user must write metric_mode through
// the cfg channel only while the block is idle; the block itself does not enforce it.
// Pairs go one at a time through a small sequencer: operand capture, multiply,
// accumulate, finish, with in_ready low from multiply to finish. A last pair adds a
// result load in modes 1/2; in mode 0 the bit-serial square root, with one shared
// compare/subtract reused for every result bit, runs before it. The result sits in an
// output register, so the next vector is taken while it waits; only a second result
// behind an unaccepted one stalls the sequencer.
module vector_distance_metric_top #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 48
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [vdm_pkg::MODE_WIDTH-1:0]         cfg_data,
	// element pairs
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [ELEM_WIDTH-1:0]           first_elem,
	input  logic signed [ELEM_WIDTH-1:0]           second_elem,
	input  logic                                   first_present,
	input  logic                                   second_present,
	input  logic                                   is_last,
	// results
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [vdm_pkg::OUT_WIDTH-1:0]   metric_value,
	output logic                                   saturated
);

	localparam int NB = (ACC_WIDTH + 1) / 2;

	vdm_pkg::state_t   state_q, state_d;
	vdm_pkg::mac_ctrl_t mac_ctrl;

	logic [vdm_pkg::MODE_WIDTH-1:0]      mode_q;
	logic                                last_q;
	logic                                dot, euclid;
	logic signed [ACC_WIDTH-1:0]         sum;
	logic                                ovf;
	logic                                sqrt_start, sqrt_busy;
	logic [NB-1:0]                       root;
	logic                                out_free, out_load;
	logic                                out_valid_q;
	logic signed [vdm_pkg::OUT_WIDTH-1:0] metric_value_q;
	logic                                saturated_q;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= vdm_pkg::MODE_EUCLID;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// only bit 1 selects the dot product, so the unused code behaves as one
	assign dot    = (mode_q != vdm_pkg::MODE_EUCLID) && (mode_q != vdm_pkg::MODE_SQUARED);
	assign euclid = (mode_q == vdm_pkg::MODE_EUCLID);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			last_q <= is_last;
		end
	end

	// output register frees up in the cycle the downstream takes it
	assign out_free = !out_valid_q || out_ready;

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vdm_pkg::ST_IDLE: if (in_valid) state_d = vdm_pkg::ST_MUL;
			vdm_pkg::ST_MUL:  state_d = vdm_pkg::ST_ACC;
			vdm_pkg::ST_ACC:  state_d = vdm_pkg::ST_FIN;
			vdm_pkg::ST_FIN: begin
				priority if (!last_q) state_d = vdm_pkg::ST_IDLE;
				else if (euclid)      state_d = vdm_pkg::ST_ROOT;
				else                  state_d = vdm_pkg::ST_OUT;
			end
			vdm_pkg::ST_ROOT: if (!sqrt_busy) state_d = vdm_pkg::ST_OUT;
			vdm_pkg::ST_OUT:  if (out_free) state_d = vdm_pkg::ST_IDLE;
			default:          state_d = vdm_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready        = 1'b0;
		mac_ctrl        = '0;
		sqrt_start      = 1'b0;
		out_load        = 1'b0;
		unique case (state_q)
			vdm_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mac_ctrl.load = in_valid;
			end
			vdm_pkg::ST_MUL:  mac_ctrl.mul_en = 1'b1;
			vdm_pkg::ST_ACC:  mac_ctrl.acc_en = 1'b1;
			vdm_pkg::ST_FIN:  sqrt_start = last_q && euclid;
			vdm_pkg::ST_ROOT: ;
			vdm_pkg::ST_OUT: begin
				out_load     = out_free;
				mac_ctrl.clr = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	vdm_mac #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_mac (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (mac_ctrl),
		.dot            (dot),
		.first_elem     (first_elem),
		.second_elem    (second_elem),
		.first_present  (first_present),
		.second_present (second_present),
		.sum            (sum),
		.ovf            (ovf)
	);

	vdm_sqrt #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.operand (sum),
		.busy    (sqrt_busy),
		.root    (root)
	);

	// result register; a wider sum keeps its low bits, a narrower one is sign-extended
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			metric_value_q <= euclid ? vdm_pkg::OUT_WIDTH'(root)
			                         : vdm_pkg::OUT_WIDTH'(sum);
			saturated_q    <= ovf;
		end
	end

	assign out_valid    = out_valid_q;
	assign metric_value = metric_value_q;
	assign saturated    = saturated_q;

endmodule

[src/vdm_checker.sv]
module vdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] metric_value,
	input logic        saturated
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(metric_value) && $stable(saturated))
		else $error("result changed while stalled");

	// one pair in flight: input closes straight after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second pair taken while one in flight");

	// a result needs multiply, accumulate and finish after its last pair
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready, 1)
		                    && !$past(in_valid && in_ready, 2)
		                    && !$past(in_valid && in_ready, 3))
		else $error("result too soon after input transfer");

endmodule

bind vector_distance_metric_top vdm_checker u_vdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.metric_value (metric_value),
	.saturated    (saturated)
);
